@@ src/lrmn_pkg.sv @@
package lrmn_pkg;

  localparam int COORD_W   = 16;
  localparam int OFF_W     = 17;
  localparam int MAG_W     = 16;
  localparam int NORM_W    = 17;
  localparam int CNT_W     = 5;
  localparam int DIV_STEPS = 16;
  localparam int STEP_W    = 4;

  localparam logic [CNT_W-1:0]  CNT_RESET = 5'd21;
  localparam logic [NORM_W-1:0] Q_ONE     = 17'd32768;

  // one landmark request
  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
  } lrmn_in_t;

  // one normalized result
  typedef struct packed {
    logic signed [NORM_W-1:0] norm_value;
    logic                     is_last;
  } lrmn_out_t;

  // divider start request
  typedef struct packed {
    logic             start;
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] divisor;
  } lrmn_div_req_t;

  // divider status and result
  typedef struct packed {
    logic                     done;
    logic signed [NORM_W-1:0] value;
  } lrmn_div_rsp_t;

endpackage

@@ src/lrmn_stream_if.sv @@
interface lrmn_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/landmark_relative_max_normalize.sv @@
// Landmark normalizer.
// Requests arrive on in_ch, one landmark (x_coord, y_coord) each; the first
// landmark of a set is the base point. Requests are taken only while idle, and
// each one's x and y offsets are written as one pair into the offset memory.
// After point_count landmarks (cfg_ch, default 21) the block stops taking
// requests and sends 2*point_count results on out_ch, x then y per point,
// each the offset divided by the largest absolute offset in Q1.15
// (32768 = +1.0); is_last marks the final result. A set of all-zero offsets
// gives zeros.
// Each result comes from the 16-step shared divider: per point the pair is
// read from memory (S_RD), then for x and then y the divider is started
// (S_START), awaited (S_DIV) and its result loaded into the output register
// (S_OUT). No new landmark is taken until the last result of a set has been
// loaded.
// A stalled receiver holds the current result in the output register; the
// divider waits behind it. Reset clears the set in progress and sets
// point_count to 21; the memory needs no clearing.
module landmark_relative_max_normalize #(
  parameter int MAX_POINTS = 21
) (
  input  logic          clk,
  input  logic          rst_n,
  lrmn_stream_if.sink   in_ch,
  lrmn_stream_if.source out_ch,
  lrmn_stream_if.sink   cfg_ch
);

  localparam int AW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PAIR_W = 2 * lrmn_pkg::OFF_W;
  localparam logic [lrmn_pkg::CNT_W:0]   MAXP_EXT = (lrmn_pkg::CNT_W + 1)'(MAX_POINTS);
  localparam logic [lrmn_pkg::CNT_W-1:0] MAXP     = lrmn_pkg::CNT_W'(MAX_POINTS);
  localparam logic [lrmn_pkg::CNT_W-1:0] LAST_SLOT = lrmn_pkg::CNT_W'(MAX_POINTS - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RD    = 5'b00010,
    S_START = 5'b00100,
    S_DIV   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [lrmn_pkg::CNT_W-1:0]      cfg_r;
  logic [lrmn_pkg::CNT_W-1:0]      eff_cnt;
  logic [lrmn_pkg::CNT_W-1:0]      pidx_r, pidx_nxt;
  logic [lrmn_pkg::CNT_W-1:0]      emit_cnt_r, emit_cnt_nxt;
  logic [lrmn_pkg::CNT_W-1:0]      emit_pt_r, emit_pt_nxt;
  logic                            half_r, half_nxt;
  logic signed [lrmn_pkg::COORD_W-1:0] base_x_r, base_y_r;
  logic [lrmn_pkg::MAG_W-1:0]      max_abs_r;
  logic                            out_valid_r, out_valid_nxt;
  lrmn_pkg::lrmn_out_t             out_data_r;

  logic [PAIR_W-1:0]               mem [MAX_POINTS];
  logic [PAIR_W-1:0]               rd_data_r;

  logic                            in_fire;
  logic                            first_pt;
  logic signed [lrmn_pkg::COORD_W-1:0] bx, by;
  logic signed [lrmn_pkg::OFF_W-1:0]   dx, dy, dx_abs, dy_abs;
  logic [lrmn_pkg::MAG_W-1:0]      max_base, max_a, max_b;
  logic [lrmn_pkg::CNT_W-1:0]      pidx_inc;
  logic                            set_done;
  logic [lrmn_pkg::CNT_W-1:0]      slot;
  logic                            last_pt;
  logic                            out_load;
  logic signed [lrmn_pkg::OFF_W-1:0]   sel_off, sel_abs;

  lrmn_pkg::lrmn_div_req_t         div_req;
  lrmn_pkg::lrmn_div_rsp_t         div_rsp;

  // configuration register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= lrmn_pkg::CNT_RESET;
    end else if (cfg_ch.valid) begin
      cfg_r <= cfg_ch.data;
    end
  end

  // clamp the count to 1..MAX_POINTS
  always_comb begin
    if (cfg_r == '0) begin
      eff_cnt = lrmn_pkg::CNT_W'(1);
    end else if ({1'b0, cfg_r} > MAXP_EXT) begin
      eff_cnt = MAXP;
    end else begin
      eff_cnt = cfg_r;
    end
  end

  // offsets and running maximum for an incoming landmark
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign first_pt    = (pidx_r == '0);

  always_comb begin
    bx = first_pt ? in_ch.data.x_coord : base_x_r;
    by = first_pt ? in_ch.data.y_coord : base_y_r;
    dx = lrmn_pkg::OFF_W'(in_ch.data.x_coord) - lrmn_pkg::OFF_W'(bx);
    dy = lrmn_pkg::OFF_W'(in_ch.data.y_coord) - lrmn_pkg::OFF_W'(by);
    dx_abs = dx[lrmn_pkg::OFF_W-1] ? -dx : dx;
    dy_abs = dy[lrmn_pkg::OFF_W-1] ? -dy : dy;
    max_base = first_pt ? '0 : max_abs_r;
    max_a = (dx_abs[lrmn_pkg::MAG_W-1:0] > max_base) ? dx_abs[lrmn_pkg::MAG_W-1:0] : max_base;
    max_b = (dy_abs[lrmn_pkg::MAG_W-1:0] > max_a) ? dy_abs[lrmn_pkg::MAG_W-1:0] : max_a;
    pidx_inc = pidx_r + 1'b1;
    set_done = (pidx_inc >= eff_cnt);
    slot = ({1'b0, pidx_r} >= MAXP_EXT) ? LAST_SLOT : pidx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_x_r  <= '0;
      base_y_r  <= '0;
      max_abs_r <= '0;
    end else if (in_fire) begin
      base_x_r  <= bx;
      base_y_r  <= by;
      max_abs_r <= max_b;
    end
  end

  // offset memory: one write port on accept, one registered read port.
  // Writes happen only while idle; reads are not gated and follow emit_pt_r.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem[slot[AW-1:0]] <= {dx, dy};
    end
    rd_data_r <= mem[emit_pt_r[AW-1:0]];
  end

  // pick the half of the pair and start the divider
  always_comb begin
    sel_off = half_r ? rd_data_r[lrmn_pkg::OFF_W-1:0] : rd_data_r[PAIR_W-1:lrmn_pkg::OFF_W];
    sel_abs = sel_off[lrmn_pkg::OFF_W-1] ? -sel_off : sel_off;
    div_req.start   = (state_r == S_START);
    div_req.neg     = sel_off[lrmn_pkg::OFF_W-1];
    div_req.mag     = sel_abs[lrmn_pkg::MAG_W-1:0];
    div_req.divisor = max_abs_r;
  end

  lrmn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign last_pt  = (emit_pt_r == (emit_cnt_r - 1'b1));
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    pidx_nxt     = pidx_r;
    emit_cnt_nxt = emit_cnt_r;
    emit_pt_nxt  = emit_pt_r;
    half_nxt     = half_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (set_done) begin
            pidx_nxt     = '0;
            emit_cnt_nxt = eff_cnt;
            emit_pt_nxt  = '0;
            half_nxt     = 1'b0;
            state_nxt    = S_RD;
          end else begin
            pidx_nxt = pidx_inc;
          end
        end
      end
      S_RD: begin
        state_nxt = S_START;
      end
      S_START: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          if (!half_r) begin
            half_nxt  = 1'b1;
            state_nxt = S_START;
          end else if (last_pt) begin
            state_nxt = S_IDLE;
          end else begin
            half_nxt    = 1'b0;
            emit_pt_nxt = emit_pt_r + 1'b1;
            state_nxt   = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pidx_r     <= '0;
      emit_cnt_r <= lrmn_pkg::CNT_W'(1);
      emit_pt_r  <= '0;
      half_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pidx_r     <= pidx_nxt;
      emit_cnt_r <= emit_cnt_nxt;
      emit_pt_r  <= emit_pt_nxt;
      half_r     <= half_nxt;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.norm_value <= div_rsp.value;
      out_data_r.is_last    <= half_r && last_pt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // checks
  a_pidx_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, pidx_r} < MAXP_EXT)
    else $error("point index beyond memory depth");

  a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (emit_pt_r < emit_cnt_r))
    else $error("emit pointer beyond set size");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider finished outside of wait state");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && half_r && last_pt) |=> (state_r == S_IDLE) && out_valid_r)
    else $error("last result did not end the set");

endmodule

@@ src/lrmn_div.sv @@
module lrmn_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lrmn_pkg::lrmn_div_req_t req,
  output lrmn_pkg::lrmn_div_rsp_t rsp
);

  logic                             busy_r;
  logic                             done_r;
  logic [lrmn_pkg::STEP_W-1:0]      step_r;
  logic [lrmn_pkg::MAG_W:0]         rem_r;
  logic [lrmn_pkg::MAG_W-1:0]       quo_r;
  logic [lrmn_pkg::MAG_W-1:0]       dvs_r;
  logic                             neg_r;

  logic                             ge;
  logic [lrmn_pkg::MAG_W:0]         diff;
  logic [lrmn_pkg::NORM_W-1:0]      q_full;
  logic [lrmn_pkg::NORM_W-1:0]      q_sat;

  // one restoring step: compare, subtract, shift
  always_comb begin
    ge   = rem_r >= {1'b0, dvs_r};
    diff = ge ? (rem_r - {1'b0, dvs_r}) : rem_r;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      busy_r <= (step_r != '0);
      done_r <= (step_r == '0);
    end else begin
      done_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      step_r <= lrmn_pkg::STEP_W'(lrmn_pkg::DIV_STEPS - 1);
      rem_r  <= {1'b0, req.mag};
      quo_r  <= '0;
      dvs_r  <= req.divisor;
      neg_r  <= req.neg;
    end else if (busy_r) begin
      step_r <= step_r - 1'b1;
      rem_r  <= {diff[lrmn_pkg::MAG_W-1:0], 1'b0};
      quo_r  <= {quo_r[lrmn_pkg::MAG_W-2:0], ge};
    end
  end

  // saturate at +1.0, apply sign, zero divisor gives zero
  always_comb begin
    q_full = {1'b0, quo_r};
    q_sat  = (q_full > lrmn_pkg::Q_ONE) ? lrmn_pkg::Q_ONE : q_full;
    rsp.done = done_r;
    if (dvs_r == '0) begin
      rsp.value = '0;
    end else if (neg_r) begin
      rsp.value = -q_sat;
    end else begin
      rsp.value = q_sat;
    end
  end

endmodule
